FILE: hdl/m3i_pkg.sv
// ----------------------------------------------------------------------------
// m3i_pkg
// shared widths, types and request/result payloads for the 3x3 inverse
// ----------------------------------------------------------------------------
package m3i_pkg;

   localparam int ELEM_WIDTH = 32;
   localparam int FRAC_BITS  = 16;

   // exact widths of the intermediates
   localparam int PROD_W     = 2 * ELEM_WIDTH;
   localparam int ADJ_W      = PROD_W + 1;
   localparam int ADJ_MAG_W  = PROD_W;
   localparam int DET_TERM_W = 3 * ELEM_WIDTH;
   localparam int DET_W      = DET_TERM_W + 3;
   localparam int DET_MAG_W  = DET_W - 1;
   localparam int NUM_SHIFT  = 2 * FRAC_BITS + 1;
   localparam int NUM_RAW_W  = ADJ_MAG_W + NUM_SHIFT;
   localparam int NUM_W      = ((NUM_RAW_W > DET_MAG_W) ? NUM_RAW_W : DET_MAG_W) + 1;
   localparam int DEN_W      = DET_MAG_W + 1;
   localparam int QUO_W      = ELEM_WIDTH;
   localparam int WIDE_W     = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

   typedef logic signed [ELEM_WIDTH-1:0] elem_type;
   typedef logic signed [PROD_W-1:0]     prod_type;
   typedef logic signed [ADJ_W-1:0]      adj_type;
   typedef logic signed [DET_W-1:0]      det_type;

   typedef elem_type mat_type     [3][3];
   typedef elem_type row_type     [3];
   typedef adj_type  adj_mat_type [3][3];

   typedef struct packed {
      elem_type elem_r0_c0;
      elem_type elem_r0_c1;
      elem_type elem_r0_c2;
      elem_type elem_r1_c0;
      elem_type elem_r1_c1;
      elem_type elem_r1_c2;
      elem_type elem_r2_c0;
      elem_type elem_r2_c1;
      elem_type elem_r2_c2;
   } req_data_type;

   typedef struct packed {
      elem_type inv_r0_c0;
      elem_type inv_r0_c1;
      elem_type inv_r0_c2;
      elem_type inv_r1_c0;
      elem_type inv_r1_c1;
      elem_type inv_r1_c2;
      elem_type inv_r2_c0;
      elem_type inv_r2_c1;
      elem_type inv_r2_c2;
      logic     singular;
      logic     overflow;
   } rsp_data_type;

endpackage

FILE: hdl/m3i_if.sv
// ----------------------------------------------------------------------------
// m3i_req_if / m3i_rsp_if
// valid/ready channels carrying the matrix request and the inverse result
// ----------------------------------------------------------------------------
interface m3i_req_if import m3i_pkg::*; ();
   logic         valid;
   logic         ready;
   req_data_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface m3i_rsp_if import m3i_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_data_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/m3i_cof.sv
// ----------------------------------------------------------------------------
// m3i_cof
// two stages: 2x2 minor products, then adjugate entries
// ----------------------------------------------------------------------------
module m3i_cof import m3i_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        up_valid,
   output logic        up_ready,
   input  mat_type     up_mat,
   output logic        dn_valid,
   input  logic        dn_ready,
   output adj_mat_type dn_adj,
   output row_type     dn_row
);

   logic        v1_ff, v2_ff;
   logic        hold1, hold2;
   prod_type    prod_p_in [3][3];
   prod_type    prod_q_in [3][3];
   prod_type    prod_p_ff [3][3];
   prod_type    prod_q_ff [3][3];
   adj_type     adj_in    [3][3];
   adj_type     adj_ff    [3][3];
   row_type     row1_ff, row2_ff;

   assign hold2    = v2_ff & ~dn_ready;
   assign hold1    = v1_ff & hold2;
   assign up_ready = ~hold1;

   for (genvar i = 0; i < 3; i++) begin : g_row
      for (genvar j = 0; j < 3; j++) begin : g_col
         localparam int RA = (j + 1) % 3;
         localparam int RB = (j + 2) % 3;
         localparam int CA = (i + 1) % 3;
         localparam int CB = (i + 2) % 3;
         assign prod_p_in[i][j] = PROD_W'(up_mat[RA][CA]) * PROD_W'(up_mat[RB][CB]);
         assign prod_q_in[i][j] = PROD_W'(up_mat[RA][CB]) * PROD_W'(up_mat[RB][CA]);
         assign adj_in[i][j]    = ADJ_W'(prod_p_ff[i][j]) - ADJ_W'(prod_q_ff[i][j]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (!hold1) v1_ff <= up_valid;
         if (!hold2) v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (!hold1) begin
         prod_p_ff <= prod_p_in;
         prod_q_ff <= prod_q_in;
         row1_ff   <= up_mat[0];
      end
      if (!hold2) begin
         adj_ff  <= adj_in;
         row2_ff <= row1_ff;
      end
   end

   assign dn_valid = v2_ff;
   assign dn_adj   = adj_ff;
   assign dn_row   = row2_ff;

endmodule

FILE: hdl/m3i_det.sv
// ----------------------------------------------------------------------------
// m3i_det
// two stages: split magnitude partial products, then signed determinant sum
// ----------------------------------------------------------------------------
module m3i_det import m3i_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        up_valid,
   output logic        up_ready,
   input  adj_mat_type up_adj,
   input  row_type     up_row,
   output logic        dn_valid,
   input  logic        dn_ready,
   output adj_mat_type dn_adj,
   output det_type     dn_det
);

   logic                    v1_ff, v2_ff;
   logic                    hold1, hold2;
   logic [ELEM_WIDTH-1:0]   amag    [3];
   logic [ADJ_MAG_W-1:0]    cmag    [3];
   logic [PROD_W-1:0]       phi_in  [3];
   logic [PROD_W-1:0]       plo_in  [3];
   logic [PROD_W-1:0]       phi_ff  [3];
   logic [PROD_W-1:0]       plo_ff  [3];
   logic                    sign_in [3];
   logic                    sign_ff [3];
   logic [DET_TERM_W-1:0]   tmag    [3];
   logic [DET_W-1:0]        term    [3];
   det_type                 det_in, det_ff;
   adj_mat_type             adj1_ff, adj2_ff;

   assign hold2    = v2_ff & ~dn_ready;
   assign hold1    = v1_ff & hold2;
   assign up_ready = ~hold1;

   for (genvar j = 0; j < 3; j++) begin : g_term
      assign amag[j]    = up_row[j][ELEM_WIDTH-1] ? ELEM_WIDTH'(-up_row[j])
                                                  : ELEM_WIDTH'(up_row[j]);
      assign cmag[j]    = up_adj[j][0][ADJ_W-1] ? ADJ_MAG_W'(-up_adj[j][0])
                                                : ADJ_MAG_W'(up_adj[j][0]);
      assign phi_in[j]  = PROD_W'(amag[j]) * PROD_W'(cmag[j][ADJ_MAG_W-1 -: ELEM_WIDTH]);
      assign plo_in[j]  = PROD_W'(amag[j]) * PROD_W'(cmag[j][ELEM_WIDTH-1:0]);
      assign sign_in[j] = up_row[j][ELEM_WIDTH-1] ^ up_adj[j][0][ADJ_W-1];
      // recombine halves, apply sign
      assign tmag[j]    = (DET_TERM_W'(phi_ff[j]) << ELEM_WIDTH) + DET_TERM_W'(plo_ff[j]);
      assign term[j]    = sign_ff[j] ? -DET_W'(tmag[j]) : DET_W'(tmag[j]);
   end

   assign det_in = term[0] + term[1] + term[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (!hold1) v1_ff <= up_valid;
         if (!hold2) v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (!hold1) begin
         phi_ff  <= phi_in;
         plo_ff  <= plo_in;
         sign_ff <= sign_in;
         adj1_ff <= up_adj;
      end
      if (!hold2) begin
         det_ff  <= det_in;
         adj2_ff <= adj1_ff;
      end
   end

   assign dn_valid = v2_ff;
   assign dn_adj   = adj2_ff;
   assign dn_det   = det_ff;

endmodule

FILE: hdl/m3i_div.sv
// ----------------------------------------------------------------------------
// m3i_div
// pipelined rounding divide of nine adjugate entries by the determinant,
// one quotient bit per stage, then saturation into the result register
// ----------------------------------------------------------------------------
module m3i_div import m3i_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         up_valid,
   output logic         up_ready,
   input  adj_mat_type  up_adj,
   input  det_type      up_det,
   output logic         dn_valid,
   input  logic         dn_ready,
   output rsp_data_type dn_data
);

   localparam logic [QUO_W-1:0] HALF = QUO_W'(1) << (ELEM_WIDTH - 1);

   // stage a: magnitudes and signs
   logic                   va_ff, hold_a;
   logic [DET_MAG_W-1:0]   dmag_a_ff;
   logic                   dneg_a_ff, dzero_a_ff;
   logic [ADJ_MAG_W-1:0]   amag_a_in [3][3];
   logic [ADJ_MAG_W-1:0]   amag_a_ff [3][3];
   logic                   aneg_a_ff [3][3];
   logic                   aneg_a_in [3][3];

   // stage b: rounding numerator and doubled denominator
   logic                   vb_ff, hold_b;
   logic [NUM_W-1:0]       num_b_in  [3][3];
   logic [NUM_W-1:0]       num_b_ff  [3][3];
   logic                   neg_b_in  [3][3];
   logic                   neg_b_ff  [3][3];
   logic [DEN_W-1:0]       den_b_ff;
   logic                   zero_b_ff;

   // quotient stages, index 0 is the range check
   logic                   c_v_ff    [QUO_W+1];
   logic                   hold_c    [QUO_W+1];
   logic [WIDE_W-1:0]      c_rem_in  [QUO_W+1][3][3];
   logic [WIDE_W-1:0]      c_rem_ff  [QUO_W+1][3][3];
   logic [QUO_W-1:0]       c_quo_in  [QUO_W+1][3][3];
   logic [QUO_W-1:0]       c_quo_ff  [QUO_W+1][3][3];
   logic                   c_big_in  [QUO_W+1][3][3];
   logic                   c_big_ff  [QUO_W+1][3][3];
   logic                   c_neg_ff  [QUO_W+1][3][3];
   logic [DEN_W-1:0]       c_den_ff  [QUO_W+1];
   logic                   c_zero_ff [QUO_W+1];

   // result stage
   logic                   vo_ff, hold_o;
   elem_type               inv_in    [3][3];
   logic                   sat       [3][3];
   rsp_data_type           rsp_in, rsp_ff;

   assign hold_o   = vo_ff & ~dn_ready;
   assign hold_b   = vb_ff & hold_c[0];
   assign hold_a   = va_ff & hold_b;
   assign up_ready = ~hold_a;

   for (genvar i = 0; i < 3; i++) begin : g_r
      for (genvar j = 0; j < 3; j++) begin : g_c
         logic [QUO_W-1:0] lim, mag, smag;
         assign amag_a_in[i][j] = up_adj[i][j][ADJ_W-1] ? ADJ_MAG_W'(-up_adj[i][j])
                                                        : ADJ_MAG_W'(up_adj[i][j]);
         assign aneg_a_in[i][j] = up_adj[i][j][ADJ_W-1];
         assign num_b_in[i][j]  = (NUM_W'(amag_a_ff[i][j]) << NUM_SHIFT)
                                  + NUM_W'(dmag_a_ff);
         assign neg_b_in[i][j]  = aneg_a_ff[i][j] ^ dneg_a_ff;

         // saturate and restore sign
         assign mag          = c_quo_ff[QUO_W][i][j];
         assign lim          = c_neg_ff[QUO_W][i][j] ? HALF : HALF - QUO_W'(1);
         assign sat[i][j]    = ~c_zero_ff[QUO_W] & (c_big_ff[QUO_W][i][j] | (mag > lim));
         assign smag         = sat[i][j] ? lim : mag;
         assign inv_in[i][j] = c_zero_ff[QUO_W]       ? '0 :
                               c_neg_ff[QUO_W][i][j]  ? ELEM_WIDTH'(-smag)
                                                      : ELEM_WIDTH'(smag);
      end
   end

   for (genvar s = 0; s <= QUO_W; s++) begin : g_stage
      if (s == QUO_W) begin : g_last
         assign hold_c[s] = c_v_ff[s] & hold_o;
      end else begin : g_mid
         assign hold_c[s] = c_v_ff[s] & hold_c[s+1];
      end

      if (s == 0) begin : g_range
         for (genvar i = 0; i < 3; i++) begin : g_r
            for (genvar j = 0; j < 3; j++) begin : g_c
               assign c_big_in[s][i][j] = WIDE_W'(num_b_ff[i][j])
                                          >= (WIDE_W'(den_b_ff) << QUO_W);
               assign c_rem_in[s][i][j] = WIDE_W'(num_b_ff[i][j]);
               assign c_quo_in[s][i][j] = '0;
            end
         end
         always_ff @(posedge clock) begin
            if (reset) c_v_ff[s] <= 1'b0;
            else if (!hold_c[s]) c_v_ff[s] <= vb_ff;
         end
         always_ff @(posedge clock) begin
            if (!hold_c[s]) begin
               c_rem_ff[s]  <= c_rem_in[s];
               c_quo_ff[s]  <= c_quo_in[s];
               c_big_ff[s]  <= c_big_in[s];
               c_neg_ff[s]  <= neg_b_ff;
               c_den_ff[s]  <= den_b_ff;
               c_zero_ff[s] <= zero_b_ff;
            end
         end
      end else begin : g_bit
         localparam int B = QUO_W - s;
         for (genvar i = 0; i < 3; i++) begin : g_r
            for (genvar j = 0; j < 3; j++) begin : g_c
               logic [WIDE_W-1:0] trial;
               logic              fits;
               assign trial = WIDE_W'(c_den_ff[s-1]) << B;
               assign fits  = c_rem_ff[s-1][i][j] >= trial;
               assign c_rem_in[s][i][j] = fits ? c_rem_ff[s-1][i][j] - trial
                                               : c_rem_ff[s-1][i][j];
               assign c_quo_in[s][i][j] = c_quo_ff[s-1][i][j] | (QUO_W'(fits) << B);
               assign c_big_in[s][i][j] = c_big_ff[s-1][i][j];
            end
         end
         always_ff @(posedge clock) begin
            if (reset) c_v_ff[s] <= 1'b0;
            else if (!hold_c[s]) c_v_ff[s] <= c_v_ff[s-1];
         end
         always_ff @(posedge clock) begin
            if (!hold_c[s]) begin
               c_rem_ff[s]  <= c_rem_in[s];
               c_quo_ff[s]  <= c_quo_in[s];
               c_big_ff[s]  <= c_big_in[s];
               c_neg_ff[s]  <= c_neg_ff[s-1];
               c_den_ff[s]  <= c_den_ff[s-1];
               c_zero_ff[s] <= c_zero_ff[s-1];
            end
         end
      end
   end

   always_comb begin
      rsp_in.inv_r0_c0 = inv_in[0][0];
      rsp_in.inv_r0_c1 = inv_in[0][1];
      rsp_in.inv_r0_c2 = inv_in[0][2];
      rsp_in.inv_r1_c0 = inv_in[1][0];
      rsp_in.inv_r1_c1 = inv_in[1][1];
      rsp_in.inv_r1_c2 = inv_in[1][2];
      rsp_in.inv_r2_c0 = inv_in[2][0];
      rsp_in.inv_r2_c1 = inv_in[2][1];
      rsp_in.inv_r2_c2 = inv_in[2][2];
      rsp_in.singular  = c_zero_ff[QUO_W];
      rsp_in.overflow  = sat[0][0] | sat[0][1] | sat[0][2] |
                         sat[1][0] | sat[1][1] | sat[1][2] |
                         sat[2][0] | sat[2][1] | sat[2][2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         if (!hold_a) va_ff <= up_valid;
         if (!hold_b) vb_ff <= va_ff;
         if (!hold_o) vo_ff <= c_v_ff[QUO_W];
      end
   end

   always_ff @(posedge clock) begin
      if (!hold_a) begin
         dneg_a_ff  <= up_det[DET_W-1];
         dzero_a_ff <= (up_det == '0);
         dmag_a_ff  <= up_det[DET_W-1] ? DET_MAG_W'(-up_det) : DET_MAG_W'(up_det);
         amag_a_ff  <= amag_a_in;
         aneg_a_ff  <= aneg_a_in;
      end
      if (!hold_b) begin
         num_b_ff  <= num_b_in;
         neg_b_ff  <= neg_b_in;
         den_b_ff  <= DEN_W'(dmag_a_ff) << 1;
         zero_b_ff <= dzero_a_ff;
      end
      if (!hold_o) rsp_ff <= rsp_in;
   end

   assign dn_valid = vo_ff;
   assign dn_data  = rsp_ff;

endmodule

FILE: hdl/matrix3_inverse.sv
// ----------------------------------------------------------------------------
// matrix3_inverse
// 3x3 signed fixed-point matrix inverse by adjugate over determinant
// ----------------------------------------------------------------------------
//  channel   dir   handshake       payload
//  req_bus   in    valid / ready   nine elements, row-major, signed Q16.16
//  rsp_bus   out   valid / ready   nine inverse entries, singular, overflow
//
//  one request per cycle while the result is taken; the restoring divider
//  is a range-check stage plus one quotient bit per stage
//  reset clears only the stage valid bits; payload registers are not reset
//  each stage holds only while it and every stage after it are full, so a
//  stalled result keeps taking requests until the bubbles are used up
// ----------------------------------------------------------------------------
module matrix3_inverse import m3i_pkg::*; (
   input logic       clock,
   input logic       reset,
   m3i_req_if.sink   req_bus,
   m3i_rsp_if.source rsp_bus
);

   mat_type     req_mat;
   logic        cof_valid, cof_ready;
   adj_mat_type cof_adj;
   row_type     cof_row;
   logic        det_valid, det_ready;
   adj_mat_type det_adj;
   det_type     det_val;

   // unpack the request into a row-major matrix
   always_comb begin
      req_mat[0][0] = req_bus.data.elem_r0_c0;
      req_mat[0][1] = req_bus.data.elem_r0_c1;
      req_mat[0][2] = req_bus.data.elem_r0_c2;
      req_mat[1][0] = req_bus.data.elem_r1_c0;
      req_mat[1][1] = req_bus.data.elem_r1_c1;
      req_mat[1][2] = req_bus.data.elem_r1_c2;
      req_mat[2][0] = req_bus.data.elem_r2_c0;
      req_mat[2][1] = req_bus.data.elem_r2_c1;
      req_mat[2][2] = req_bus.data.elem_r2_c2;
   end

   // minors and adjugate
   m3i_cof u_cof (
      .clock    (clock),
      .reset    (reset),
      .up_valid (req_bus.valid),
      .up_ready (req_bus.ready),
      .up_mat   (req_mat),
      .dn_valid (cof_valid),
      .dn_ready (cof_ready),
      .dn_adj   (cof_adj),
      .dn_row   (cof_row)
   );

   // determinant along the first row
   m3i_det u_det (
      .clock    (clock),
      .reset    (reset),
      .up_valid (cof_valid),
      .up_ready (cof_ready),
      .up_adj   (cof_adj),
      .up_row   (cof_row),
      .dn_valid (det_valid),
      .dn_ready (det_ready),
      .dn_adj   (det_adj),
      .dn_det   (det_val)
   );

   // rounding divide, saturation, result register
   m3i_div u_div (
      .clock    (clock),
      .reset    (reset),
      .up_valid (det_valid),
      .up_ready (det_ready),
      .up_adj   (det_adj),
      .up_det   (det_val),
      .dn_valid (rsp_bus.valid),
      .dn_ready (rsp_bus.ready),
      .dn_data  (rsp_bus.data)
   );

`ifndef ASSERT_OFF
   // a singular matrix gives an all-zero result with no overflow
   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.data.singular |->
         rsp_bus.data.inv_r0_c0 == '0 && rsp_bus.data.inv_r0_c1 == '0 &&
         rsp_bus.data.inv_r0_c2 == '0 && rsp_bus.data.inv_r1_c0 == '0 &&
         rsp_bus.data.inv_r1_c1 == '0 && rsp_bus.data.inv_r1_c2 == '0 &&
         rsp_bus.data.inv_r2_c0 == '0 && rsp_bus.data.inv_r2_c1 == '0 &&
         rsp_bus.data.inv_r2_c2 == '0 && !rsp_bus.data.overflow)
      else $error("singular result not cleared");

   // back-pressure at the input only comes from a stalled full result
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> rsp_bus.valid && !rsp_bus.ready)
      else $error("request stalled without a waiting result");

   // overflow means some entry sits at a saturation bound
   a_overflow_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.data.overflow |->
         !rsp_bus.data.singular &&
         (rsp_bus.data.inv_r0_c0 == {1'b0, {(ELEM_WIDTH-1){1'b1}}} ||
          rsp_bus.data.inv_r0_c0 == {1'b1, {(ELEM_WIDTH-1){1'b0}}} ||
          rsp_bus.data.inv_r0_c1 == {1'b0, {(ELEM_WIDTH-1){1'b1}}} ||
          rsp_bus.data.inv_r0_c1 == {1'b1, {(ELEM_WIDTH-1){1'b0}}} ||
          rsp_bus.data.inv_r0_c2 == {1'b0, {(ELEM_WIDTH-1){1'b1}}} ||
          rsp_bus.data.inv_r0_c2 == {1'b1, {(ELEM_WIDTH-1){1'b0}}} ||
          rsp_bus.data.inv_r1_c0 == {1'b0, {(ELEM_WIDTH-1){1'b1}}} ||
          rsp_bus.data.inv_r1_c0 == {1'b1, {(ELEM_WIDTH-1){1'b0}}} ||
          rsp_bus.data.inv_r1_c1 == {1'b0, {(ELEM_WIDTH-1){1'b1}}} ||
          rsp_bus.data.inv_r1_c1 == {1'b1, {(ELEM_WIDTH-1){1'b0}}} ||
          rsp_bus.data.inv_r1_c2 == {1'b0, {(ELEM_WIDTH-1){1'b1}}} ||
          rsp_bus.data.inv_r1_c2 == {1'b1, {(ELEM_WIDTH-1){1'b0}}} ||
          rsp_bus.data.inv_r2_c0 == {1'b0, {(ELEM_WIDTH-1){1'b1}}} ||
          rsp_bus.data.inv_r2_c0 == {1'b1, {(ELEM_WIDTH-1){1'b0}}} ||
          rsp_bus.data.inv_r2_c1 == {1'b0, {(ELEM_WIDTH-1){1'b1}}} ||
          rsp_bus.data.inv_r2_c1 == {1'b1, {(ELEM_WIDTH-1){1'b0}}} ||
          rsp_bus.data.inv_r2_c2 == {1'b0, {(ELEM_WIDTH-1){1'b1}}} ||
          rsp_bus.data.inv_r2_c2 == {1'b1, {(ELEM_WIDTH-1){1'b0}}}))
      else $error("overflow without a saturated entry");
`endif

endmodule
